### sv/midi_file_stream_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// MIDI file stream parser assertion macros
// Shared property forms for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_STREAM_PARSER_UNIT_ASSERT_SVH
`define MIDI_FILE_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define MFSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfsp check failed: same-cycle implication");

// next-cycle implication
`define MFSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfsp check failed: next-cycle implication");

`endif

### sv/mfsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser package
// Phase and result kind codes, file tags and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mfsp_pkg;

    localparam logic [31:0] TAG_FILE  = 32'h4D54_6864;
    localparam logic [31:0] TAG_TRACK = 32'h4D54_726B;
    localparam logic [31:0] HDR_LEN   = 32'd6;

    localparam logic [7:0] STATUS_MIN = 8'h80;
    localparam logic [7:0] SYS_MIN    = 8'hF0;
    localparam logic [7:0] SYSEX_ST   = 8'hF0;
    localparam logic [7:0] SYSEX_END  = 8'hF7;
    localparam logic [7:0] META_ST    = 8'hFF;
    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [3:0] TYPE_PROG  = 4'hC;
    localparam logic [3:0] TYPE_PRESS = 4'hD;

    typedef enum logic [3:0] {
        PH_FTAG   = 4'd0,
        PH_HLEN   = 4'd1,
        PH_HFMT   = 4'd2,
        PH_HTRK   = 4'd3,
        PH_HDIV   = 4'd4,
        PH_TTAG   = 4'd5,
        PH_TLEN   = 4'd6,
        PH_DELTA  = 4'd7,
        PH_STATUS = 4'd8,
        PH_P1     = 4'd9,
        PH_P2     = 4'd10,
        PH_MTYPE  = 4'd11,
        PH_MLEN   = 4'd12,
        PH_MDATA  = 4'd13,
        PH_SYSEX  = 4'd14,
        PH_IDLE   = 4'd15
    } phase_t;

    typedef enum logic [3:0] {
        K_HEADER        = 4'd0,
        K_CHANNEL       = 4'd1,
        K_META_HDR      = 4'd2,
        K_META_DATA     = 4'd3,
        K_TRACK_END     = 4'd4,
        K_ERR_FILE_TAG  = 4'd5,
        K_ERR_HDR_LEN   = 4'd6,
        K_ERR_TRACK_TAG = 4'd7,
        K_ERR_STATUS    = 4'd8,
        K_ERR_VARLEN    = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [27:0]  delta;
        logic [7:0]   event_type;
        logic [3:0]   channel;
        logic [7:0]   param_first;
        logic [7:0]   param_second;
        logic [27:0]  meta_length;
        logic [7:0]   data_byte;
        logic [15:0]  file_format;
        logic [15:0]  track_count;
        logic         division_flag;
        logic [14:0]  time_division;
    } result_t;

endpackage

`default_nettype wire

### sv/midi_file_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser
// Parses a Standard MIDI File byte by byte into header, event and error results.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle while input ready is high and
// never stalls the input on its own: every byte is processed by a single
// state update in the cycle it is accepted, and a byte that completes a
// result loads it into a one-entry output register, visible on the master
// side the next cycle. Input ready drops only while that register holds a
// result the consumer has not taken.
`default_nettype none

module midi_file_stream_parser_unit
    import mfsp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // in_byte[7:0]
    input  wire logic [0:0]   s_axis_tuser,   // file_start[0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // delta[27:0], event_type[35:28], channel[39:36], param_first[47:40],
    // param_second[55:48], meta_length[83:56], data_byte[91:84],
    // file_format[107:92], track_count[123:108], division_flag[124],
    // time_division[139:125], zero pad[143:140]
    output logic [143:0]      m_axis_tdata,
    output logic [3:0]        m_axis_tuser    // kind[3:0]
);

    phase_t       phase_reg, phase_next, cur_phase;
    logic [2:0]   idx_reg, idx_next, cur_idx, idx_inc;
    logic [31:0]  gw_reg, gw_next, cur_gw, gw_shift;
    logic [15:0]  fmt_reg, fmt_next, cur_fmt;
    logic [15:0]  trk_reg, trk_next, cur_trk, trk_dec;
    logic [7:0]   rs_reg, rs_next, cur_rs;
    logic [27:0]  dacc_reg, dacc_next, cur_dacc;
    logic [2:0]   vl_reg, vl_next, cur_vl, vl_inc;
    logic [15:0]  held_reg, held_next, cur_held;
    logic [7:0]   mkind_reg, mkind_next, cur_mkind;
    logic [27:0]  mrem_reg, mrem_next, cur_mrem, mrem_dec;
    logic         eotp_reg, eotp_next, cur_eotp;
    logic [27:0]  vl_src, vl_acc;
    logic         in_fire, load, out_valid_reg, out_valid_next;
    logic [7:0]   b;
    result_t      res, res_reg;
    logic         res_valid;

    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign load          = in_fire && res_valid;
    assign b             = s_axis_tdata;

    always_comb
    begin
        if (s_axis_tuser[0])
        begin
            cur_phase = PH_FTAG;
            cur_idx   = '0;
            cur_gw    = '0;
            cur_fmt   = '0;
            cur_trk   = '0;
            cur_rs    = '0;
            cur_dacc  = '0;
            cur_vl    = '0;
            cur_held  = '0;
            cur_mkind = '0;
            cur_mrem  = '0;
            cur_eotp  = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_idx   = idx_reg;
            cur_gw    = gw_reg;
            cur_fmt   = fmt_reg;
            cur_trk   = trk_reg;
            cur_rs    = rs_reg;
            cur_dacc  = dacc_reg;
            cur_vl    = vl_reg;
            cur_held  = held_reg;
            cur_mkind = mkind_reg;
            cur_mrem  = mrem_reg;
            cur_eotp  = eotp_reg;
        end
    end

    assign idx_inc  = cur_idx + 3'd1;
    assign gw_shift = {cur_gw[23:0], b};
    assign vl_inc   = cur_vl + 3'd1;
    assign vl_src   = (cur_vl == 3'd0) ? 28'd0
                    : ((cur_phase == PH_MLEN) ? cur_mrem : cur_dacc);
    assign vl_acc   = {vl_src[20:0], b[6:0]};
    assign trk_dec  = cur_trk - 16'd1;
    assign mrem_dec = cur_mrem - 28'd1;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        gw_next    = gw_reg;
        fmt_next   = fmt_reg;
        trk_next   = trk_reg;
        rs_next    = rs_reg;
        dacc_next  = dacc_reg;
        vl_next    = vl_reg;
        held_next  = held_reg;
        mkind_next = mkind_reg;
        mrem_next  = mrem_reg;
        eotp_next  = eotp_reg;
        res        = '0;
        res_valid  = 1'b0;
        if (in_fire)
        begin
            phase_next = cur_phase;
            idx_next   = cur_idx;
            gw_next    = cur_gw;
            fmt_next   = cur_fmt;
            trk_next   = cur_trk;
            rs_next    = cur_rs;
            dacc_next  = cur_dacc;
            vl_next    = cur_vl;
            held_next  = cur_held;
            mkind_next = cur_mkind;
            mrem_next  = cur_mrem;
            eotp_next  = cur_eotp;
            unique case (cur_phase)
                PH_FTAG, PH_HLEN, PH_TTAG, PH_TLEN:
                begin
                    gw_next  = gw_shift;
                    idx_next = idx_inc;
                    if (idx_inc >= 3'd4)
                    begin
                        idx_next = '0;
                        gw_next  = '0;
                        if (cur_phase == PH_FTAG)
                        begin
                            if (gw_shift != TAG_FILE)
                            begin
                                gw_next    = gw_shift;
                                res.kind   = K_ERR_FILE_TAG;
                                res_valid  = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_HLEN;
                            end
                        end
                        else if (cur_phase == PH_HLEN)
                        begin
                            if (gw_shift != HDR_LEN)
                            begin
                                gw_next    = gw_shift;
                                res.kind   = K_ERR_HDR_LEN;
                                res_valid  = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_HFMT;
                            end
                        end
                        else if (cur_phase == PH_TTAG)
                        begin
                            if (gw_shift != TAG_TRACK)
                            begin
                                gw_next    = gw_shift;
                                res.kind   = K_ERR_TRACK_TAG;
                                res_valid  = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                rs_next    = '0;
                                phase_next = PH_TLEN;
                            end
                        end
                        else
                        begin
                            vl_next    = '0;
                            phase_next = PH_DELTA;
                        end
                    end
                end
                PH_HFMT, PH_HTRK, PH_HDIV:
                begin
                    gw_next  = gw_shift;
                    idx_next = idx_inc;
                    if (idx_inc >= 3'd2)
                    begin
                        idx_next = '0;
                        gw_next  = '0;
                        if (cur_phase == PH_HFMT)
                        begin
                            fmt_next   = gw_shift[15:0];
                            phase_next = PH_HTRK;
                        end
                        else if (cur_phase == PH_HTRK)
                        begin
                            trk_next   = gw_shift[15:0];
                            phase_next = PH_HDIV;
                        end
                        else
                        begin
                            res.kind          = K_HEADER;
                            res.file_format   = cur_fmt;
                            res.track_count   = cur_trk;
                            res.division_flag = gw_shift[15];
                            res.time_division = gw_shift[14:0];
                            res_valid         = 1'b1;
                            phase_next = (cur_trk == 16'd0) ? PH_IDLE : PH_TTAG;
                        end
                    end
                end
                PH_DELTA:
                begin
                    dacc_next = vl_acc;
                    vl_next   = vl_inc;
                    if (!b[7])
                    begin
                        vl_next    = '0;
                        phase_next = PH_STATUS;
                    end
                    else if (vl_inc >= 3'd4)
                    begin
                        vl_next    = '0;
                        res.kind   = K_ERR_VARLEN;
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_STATUS, PH_P1, PH_P2:
                begin
                    if (cur_phase == PH_P2)
                    begin
                        res.kind         = K_CHANNEL;
                        res.delta        = cur_dacc;
                        res.event_type   = {cur_held[15:12], 4'h0};
                        res.channel      = cur_held[11:8];
                        res.param_first  = cur_held[7:0];
                        res.param_second = b;
                        res_valid        = 1'b1;
                        phase_next       = PH_DELTA;
                    end
                    else if (cur_phase == PH_P1 || b < STATUS_MIN)
                    begin
                        if (cur_phase == PH_STATUS && cur_rs == 8'd0)
                        begin
                            res.kind   = K_ERR_STATUS;
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            held_next = (cur_phase == PH_P1) ? {cur_held[15:8], b}
                                                             : {cur_rs, b};
                            if (held_next[15:12] == TYPE_PROG
                                || held_next[15:12] == TYPE_PRESS)
                            begin
                                res.kind        = K_CHANNEL;
                                res.delta       = cur_dacc;
                                res.event_type  = {held_next[15:12], 4'h0};
                                res.channel     = held_next[11:8];
                                res.param_first = b;
                                res_valid       = 1'b1;
                                phase_next      = PH_DELTA;
                            end
                            else
                            begin
                                phase_next = PH_P2;
                            end
                        end
                    end
                    else if (b < SYS_MIN)
                    begin
                        rs_next    = b;
                        held_next  = {b, 8'h00};
                        phase_next = PH_P1;
                    end
                    else if (b == META_ST)
                    begin
                        phase_next = PH_MTYPE;
                    end
                    else if (b == SYSEX_ST)
                    begin
                        phase_next = PH_SYSEX;
                    end
                    else
                    begin
                        res.kind   = K_ERR_STATUS;
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_MTYPE:
                begin
                    mkind_next = b;
                    eotp_next  = (b == META_EOT);
                    vl_next    = '0;
                    phase_next = PH_MLEN;
                end
                PH_MLEN:
                begin
                    mrem_next = vl_acc;
                    vl_next   = vl_inc;
                    if (!b[7])
                    begin
                        vl_next = '0;
                        if (vl_acc == 28'd0 && cur_eotp)
                        begin
                            res.kind       = K_TRACK_END;
                            res.delta      = cur_dacc;
                            res.event_type = cur_mkind;
                            res_valid      = 1'b1;
                            trk_next       = trk_dec;
                            phase_next = (trk_dec == 16'd0) ? PH_IDLE : PH_TTAG;
                            idx_next       = '0;
                            gw_next        = '0;
                            eotp_next      = 1'b0;
                        end
                        else
                        begin
                            res.kind        = K_META_HDR;
                            res.delta       = cur_dacc;
                            res.event_type  = cur_mkind;
                            res.meta_length = vl_acc;
                            res_valid       = 1'b1;
                            phase_next = (vl_acc == 28'd0) ? PH_DELTA : PH_MDATA;
                        end
                    end
                    else if (vl_inc >= 3'd4)
                    begin
                        vl_next    = '0;
                        res.kind   = K_ERR_VARLEN;
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_MDATA:
                begin
                    mrem_next = mrem_dec;
                    res.delta      = cur_dacc;
                    res.event_type = cur_mkind;
                    res.data_byte  = b;
                    res_valid      = 1'b1;
                    if (mrem_dec == 28'd0 && cur_eotp)
                    begin
                        res.kind   = K_TRACK_END;
                        trk_next   = trk_dec;
                        phase_next = (trk_dec == 16'd0) ? PH_IDLE : PH_TTAG;
                        idx_next   = '0;
                        gw_next    = '0;
                        eotp_next  = 1'b0;
                    end
                    else
                    begin
                        res.kind = K_META_DATA;
                        if (mrem_dec == 28'd0)
                        begin
                            phase_next = PH_DELTA;
                        end
                    end
                end
                PH_SYSEX:
                begin
                    if (b == SYSEX_END)
                    begin
                        phase_next = PH_DELTA;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FTAG;
            idx_reg       <= '0;
            gw_reg        <= '0;
            fmt_reg       <= '0;
            trk_reg       <= '0;
            rs_reg        <= '0;
            dacc_reg      <= '0;
            vl_reg        <= '0;
            held_reg      <= '0;
            mkind_reg     <= '0;
            mrem_reg      <= '0;
            eotp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            gw_reg        <= gw_next;
            fmt_reg       <= fmt_next;
            trk_reg       <= trk_next;
            rs_reg        <= rs_next;
            dacc_reg      <= dacc_next;
            vl_reg        <= vl_next;
            held_reg      <= held_next;
            mkind_reg     <= mkind_next;
            mrem_reg      <= mrem_next;
            eotp_reg      <= eotp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {4'b0000, res_reg.time_division, res_reg.division_flag,
                            res_reg.track_count, res_reg.file_format,
                            res_reg.data_byte, res_reg.meta_length,
                            res_reg.param_second, res_reg.param_first,
                            res_reg.channel, res_reg.event_type, res_reg.delta};

`include "midi_file_stream_parser_unit_assert.svh"

    `MFSP_ASSERT_NEXT(a_err_goes_idle,
        load && (res.kind == K_ERR_FILE_TAG || res.kind == K_ERR_HDR_LEN
        || res.kind == K_ERR_TRACK_TAG || res.kind == K_ERR_STATUS
        || res.kind == K_ERR_VARLEN), phase_reg == PH_IDLE)
    `MFSP_ASSERT_NEXT(a_track_end_exit, load && res.kind == K_TRACK_END,
        (phase_reg == PH_TTAG || phase_reg == PH_IDLE) && idx_reg == 3'd0)
    `MFSP_ASSERT_NOW(a_idx_range, 1'b1, !idx_reg[2] && !vl_reg[2])
    `MFSP_ASSERT_NOW(a_no_overwrite, load, s_axis_tready)

endmodule

`default_nettype wire

### tb/sv/tb_midi_file_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser testbench
// Streams generated Standard MIDI Files, clean and flawed, into the parser
// under several idle and stall patterns, predicts every header, event, meta
// and error result, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midi_file_stream_parser_unit;
    import mfsp_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 1000;
    localparam int MAX_REPORTS = 40;

    localparam int VL_MORE = 0;
    localparam int VL_DONE = 1;
    localparam int VL_LONG = 2;

    typedef enum int {
        FL_NONE,
        FL_FILE_TAG,
        FL_HDR_LEN,
        FL_TRACK_TAG,
        FL_BAD_STATUS,
        FL_ORPHAN_DATA,
        FL_LONG_DELTA,
        FL_LONG_MLEN,
        FL_RESTART,
        FL_ZERO_TRACKS,
        FL_COUNT
    } flaw_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata = 8'h00;   // in_byte[7:0]
    logic [0:0]     s_axis_tuser = 1'b0;    // file_start[0]
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // delta[27:0], event_type[35:28], channel[39:36], param_first[47:40],
    // param_second[55:48], meta_length[83:56], data_byte[91:84],
    // file_format[107:92], track_count[123:108], division_flag[124],
    // time_division[139:125]
    logic [143:0]   m_axis_tdata;
    logic [3:0]     m_axis_tuser;           // kind[3:0]

    midi_file_stream_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    phase_t         cur_phase;
    logic [2:0]     tag_index;
    logic [31:0]    tag_word;
    logic [15:0]    fmt_word;
    logic [15:0]    tracks_remaining;
    logic [7:0]     status_latch;
    logic [27:0]    delta_ticks;
    logic [2:0]     varlen_count;
    logic [15:0]    event_hold;
    logic [7:0]     meta_type;
    logic [27:0]    meta_left;
    logic           eot_pending;

    result_t        pending_events[$];
    logic [8:0]     stim_q[$];
    bit             stim_first;
    int             file_count = 0;
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_starts = 0;
    int             hold_len = 0;
    int             hold_ack = 0;
    int             hold_left = 0;
    int             quiet_cycles = 0;

    task clear_parser();
        cur_phase        = PH_FTAG;
        tag_index        = '0;
        tag_word         = '0;
        fmt_word         = '0;
        tracks_remaining = '0;
        status_latch     = '0;
        delta_ticks      = '0;
        varlen_count     = '0;
        event_hold       = '0;
        meta_type        = '0;
        meta_left        = '0;
        eot_pending      = 1'b0;
    endtask

    function automatic bit gather_byte(input logic [7:0] b, input int n);
        tag_word  = {tag_word[23:0], b};
        tag_index = tag_index + 3'd1;
        if (tag_index >= n)
        begin
            tag_index = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic take_varlen(input logic [7:0] b, inout logic [27:0] acc, output int code);
        if (varlen_count == 3'd0)
            acc = '0;
        acc = {acc[20:0], b[6:0]};
        varlen_count = varlen_count + 3'd1;
        if (!b[7])
        begin
            varlen_count = 3'd0;
            code = VL_DONE;
        end
        else if (varlen_count >= 3'd4)
        begin
            varlen_count = 3'd0;
            code = VL_LONG;
        end
        else
            code = VL_MORE;
    endtask

    function automatic result_t error_result(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        cur_phase = PH_IDLE;
        return r;
    endfunction

    function automatic result_t channel_result(input logic [7:0] second);
        result_t r;
        r = '0;
        r.kind         = K_CHANNEL;
        r.delta        = delta_ticks;
        r.event_type   = {event_hold[15:12], 4'h0};
        r.channel      = event_hold[11:8];
        r.param_first  = event_hold[7:0];
        r.param_second = second;
        cur_phase = PH_DELTA;
        return r;
    endfunction

    function automatic result_t track_end_result(input logic [7:0] last);
        result_t r;
        r = '0;
        r.kind       = K_TRACK_END;
        r.delta      = delta_ticks;
        r.event_type = meta_type;
        r.data_byte  = last;
        tracks_remaining = tracks_remaining - 16'd1;
        if (tracks_remaining == 16'd0)
            cur_phase = PH_IDLE;
        else
            cur_phase = PH_TTAG;
        tag_index   = '0;
        tag_word    = '0;
        eot_pending = 1'b0;
        return r;
    endfunction

    task automatic finish_first_param(output result_t r, output bit hit);
        r = '0;
        hit = 1'b0;
        if (event_hold[15:12] == TYPE_PROG || event_hold[15:12] == TYPE_PRESS)
        begin
            r = channel_result(8'h00);
            hit = 1'b1;
        end
        else
            cur_phase = PH_P2;
    endtask

    task automatic parse_file_byte(input logic [7:0] b, input logic start);
        result_t r;
        bit      hit;
        int      code;
        r = '0;
        hit = 1'b0;
        if (start)
            clear_parser();
        case (cur_phase)
            PH_FTAG:
                if (gather_byte(b, 4))
                begin
                    if (tag_word != TAG_FILE)
                    begin
                        r = error_result(K_ERR_FILE_TAG);
                        hit = 1'b1;
                    end
                    else
                    begin
                        tag_word = '0;
                        cur_phase = PH_HLEN;
                    end
                end
            PH_HLEN:
                if (gather_byte(b, 4))
                begin
                    if (tag_word != HDR_LEN)
                    begin
                        r = error_result(K_ERR_HDR_LEN);
                        hit = 1'b1;
                    end
                    else
                    begin
                        tag_word = '0;
                        cur_phase = PH_HFMT;
                    end
                end
            PH_HFMT:
                if (gather_byte(b, 2))
                begin
                    fmt_word = tag_word[15:0];
                    tag_word = '0;
                    cur_phase = PH_HTRK;
                end
            PH_HTRK:
                if (gather_byte(b, 2))
                begin
                    tracks_remaining = tag_word[15:0];
                    tag_word = '0;
                    cur_phase = PH_HDIV;
                end
            PH_HDIV:
                if (gather_byte(b, 2))
                begin
                    r.kind          = K_HEADER;
                    r.file_format   = fmt_word;
                    r.track_count   = tracks_remaining;
                    r.division_flag = tag_word[15];
                    r.time_division = tag_word[14:0];
                    hit = 1'b1;
                    tag_word = '0;
                    if (tracks_remaining == 16'd0)
                        cur_phase = PH_IDLE;
                    else
                        cur_phase = PH_TTAG;
                end
            PH_TTAG:
                if (gather_byte(b, 4))
                begin
                    if (tag_word != TAG_TRACK)
                    begin
                        r = error_result(K_ERR_TRACK_TAG);
                        hit = 1'b1;
                    end
                    else
                    begin
                        tag_word = '0;
                        status_latch = '0;
                        cur_phase = PH_TLEN;
                    end
                end
            PH_TLEN:
                if (gather_byte(b, 4))
                begin
                    tag_word = '0;
                    varlen_count = '0;
                    cur_phase = PH_DELTA;
                end
            PH_DELTA:
            begin
                take_varlen(b, delta_ticks, code);
                if (code == VL_LONG)
                begin
                    r = error_result(K_ERR_VARLEN);
                    hit = 1'b1;
                end
                else if (code == VL_DONE)
                    cur_phase = PH_STATUS;
            end
            PH_STATUS:
                if (b < STATUS_MIN)
                begin
                    if (status_latch == 8'h00)
                    begin
                        r = error_result(K_ERR_STATUS);
                        hit = 1'b1;
                    end
                    else
                    begin
                        event_hold = {status_latch, b};
                        finish_first_param(r, hit);
                    end
                end
                else if (b < SYS_MIN)
                begin
                    status_latch = b;
                    event_hold = {b, 8'h00};
                    cur_phase = PH_P1;
                end
                else if (b == META_ST)
                    cur_phase = PH_MTYPE;
                else if (b == SYSEX_ST)
                    cur_phase = PH_SYSEX;
                else
                begin
                    r = error_result(K_ERR_STATUS);
                    hit = 1'b1;
                end
            PH_P1:
            begin
                event_hold[7:0] = b;
                finish_first_param(r, hit);
            end
            PH_P2:
            begin
                r = channel_result(b);
                hit = 1'b1;
            end
            PH_MTYPE:
            begin
                meta_type = b;
                eot_pending = (b == META_EOT);
                varlen_count = '0;
                cur_phase = PH_MLEN;
            end
            PH_MLEN:
            begin
                take_varlen(b, meta_left, code);
                if (code == VL_LONG)
                begin
                    r = error_result(K_ERR_VARLEN);
                    hit = 1'b1;
                end
                else if (code == VL_DONE)
                begin
                    hit = 1'b1;
                    if (meta_left == 28'd0 && eot_pending)
                        r = track_end_result(8'h00);
                    else
                    begin
                        r.kind        = K_META_HDR;
                        r.delta       = delta_ticks;
                        r.event_type  = meta_type;
                        r.meta_length = meta_left;
                        if (meta_left == 28'd0)
                            cur_phase = PH_DELTA;
                        else
                            cur_phase = PH_MDATA;
                    end
                end
            end
            PH_MDATA:
            begin
                meta_left = meta_left - 28'd1;
                hit = 1'b1;
                if (meta_left == 28'd0 && eot_pending)
                    r = track_end_result(b);
                else
                begin
                    r.kind       = K_META_DATA;
                    r.delta      = delta_ticks;
                    r.event_type = meta_type;
                    r.data_byte  = b;
                    if (meta_left == 28'd0)
                        cur_phase = PH_DELTA;
                end
            end
            PH_SYSEX:
                if (b == SYSEX_END)
                    cur_phase = PH_DELTA;
            default:
                cur_phase = PH_IDLE;
        endcase
        if (hit)
            pending_events.push_back(r);
    endtask

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_file_byte(b, start);
    endtask

    task send_stream();
        @(posedge clk);
        foreach (stim_q[i])
            send_byte(stim_q[i][7:0], stim_q[i][8]);
        s_axis_tvalid <= 1'b0;
        stim_q.delete();
    endtask

    task put(input logic [7:0] b);
        stim_q.push_back({stim_first, b});
        stim_first = 1'b0;
    endtask

    task put_word(input logic [31:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            put(w[8*i +: 8]);
    endtask

    task put_varlen(input logic [27:0] v);
        int n;
        n = 1;
        if (v >= 28'h80)
            n = 2;
        if (v >= 28'h4000)
            n = 3;
        if (v >= 28'h20_0000)
            n = 4;
        if (n < 4 && $urandom_range(0, 7) == 0)
            n++;
        for (int i = n - 1; i >= 0; i--)
            put({i != 0, v[7*i +: 7]});
    endtask

    task put_long_varlen();
        repeat (4)
            put(8'($urandom_range(8'h80, 8'hFF)));
    endtask

    task put_junk();
        repeat ($urandom_range(0, 3))
            put(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [27:0] rand_delta();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return 28'($urandom_range(0, 127));
        if (sel < 75)
            return 28'($urandom_range(128, 16383));
        if (sel < 90)
            return 28'($urandom_range(16384, 28'h1F_FFFF));
        if (sel < 96)
            return 28'($urandom_range(28'h20_0000, 28'hFFF_FFFF));
        if (sel < 98)
            return 28'hFFF_FFFF;
        return 28'd0;
    endfunction

    function automatic logic [7:0] rand_meta_type();
        logic [7:0] t;
        t = 8'($urandom_range(0, 255));
        if (t == META_EOT)
            t = 8'h01;
        return t;
    endfunction

    task put_meta(input logic [7:0] mtype, input int len);
        put(META_ST);
        put(mtype);
        put_varlen(28'(len));
        repeat (len)
            put(8'($urandom_range(0, 255)));
    endtask

    task put_sysex();
        logic [7:0] b;
        put(SYSEX_ST);
        repeat ($urandom_range(0, 4))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == SYSEX_END)
                b = 8'h00;
            put(b);
        end
        put(SYSEX_END);
    endtask

    task put_channel_event(inout logic [7:0] run_status);
        logic [7:0] st;
        if (run_status != 8'h00 && $urandom_range(0, 1) == 1)
        begin
            st = run_status;
            put(8'($urandom_range(0, 127)));
        end
        else
        begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            put(st);
            put(8'($urandom_range(0, 255)));
            run_status = st;
        end
        if (st[7:4] != TYPE_PROG && st[7:4] != TYPE_PRESS)
            put(8'($urandom_range(0, 255)));
    endtask

    task put_random_event(inout logic [7:0] run_status);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            put_channel_event(run_status);
        else if (sel < 8)
            put_meta(rand_meta_type(), $urandom_range(0, 4));
        else
            put_sysex();
    endtask

    task put_track_end();
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        put_meta(META_EOT, len);
    endtask

    task put_flaw(input flaw_t flaw);
        case (flaw)
            FL_BAD_STATUS:
            begin
                put_varlen(rand_delta());
                put(8'($urandom_range(8'hF1, 8'hFE)));
            end
            FL_ORPHAN_DATA:
            begin
                put_varlen(rand_delta());
                put(8'($urandom_range(0, 127)));
            end
            FL_LONG_DELTA:
                put_long_varlen();
            FL_LONG_MLEN:
            begin
                put_varlen(rand_delta());
                put(META_ST);
                put(8'($urandom_range(0, 255)));
                put_long_varlen();
            end
            default:
            begin
                put_varlen(rand_delta());
                put(META_ST);
                put(rand_meta_type());
                put_varlen(28'($urandom_range(5, 28'hFFF_FFFF)));
                put(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task gen_file(input flaw_t flaw, input int max_events);
        logic [31:0] tag;
        logic [7:0]  run_status;
        int          nt;
        int          nev;
        int          flaw_track;
        int          flaw_event;
        bit          cut;
        cut = 1'b0;
        stim_first = 1'b1;
        tag = TAG_FILE;
        if (flaw == FL_FILE_TAG)
        begin
            tag = tag ^ (32'd1 << $urandom_range(0, 31));
            cut = 1'b1;
        end
        put_word(tag, 4);
        if (!cut)
        begin
            if (flaw == FL_HDR_LEN)
            begin
                put_word(HDR_LEN ^ (32'd1 << $urandom_range(0, 31)), 4);
                cut = 1'b1;
            end
            else
                put_word(HDR_LEN, 4);
        end
        if (!cut)
        begin
            nt = (flaw == FL_ZERO_TRACKS) ? 0 : $urandom_range(1, 2);
            put_word($urandom_range(0, 16'hFFFF), 2);
            put_word(nt, 2);
            put_word($urandom_range(0, 16'hFFFF), 2);
            flaw_track = $urandom_range(0, 1) % ((nt == 0) ? 1 : nt);
            for (int t = 0; t < nt && !cut; t++)
            begin
                run_status = 8'h00;
                tag = TAG_TRACK;
                if (flaw == FL_TRACK_TAG && t == flaw_track)
                begin
                    put_word(tag ^ (32'd1 << $urandom_range(0, 31)), 4);
                    cut = 1'b1;
                end
                else
                begin
                    put_word(tag, 4);
                    put_word($urandom, 4);
                    nev = $urandom_range(0, max_events);
                    flaw_event = (flaw == FL_ORPHAN_DATA) ? 0 : $urandom_range(0, nev);
                    for (int e = 0; e <= nev && !cut; e++)
                    begin
                        if (flaw >= FL_BAD_STATUS && flaw <= FL_RESTART &&
                            t == flaw_track && e == flaw_event)
                        begin
                            put_flaw(flaw);
                            cut = 1'b1;
                        end
                        else
                        begin
                            put_varlen(rand_delta());
                            if (e == nev)
                                put_track_end();
                            else
                                put_random_event(run_status);
                        end
                    end
                end
            end
        end
        put_junk();
    endtask

    function automatic flaw_t pick_flaw();
        if (file_count < int'(FL_COUNT))
            return flaw_t'(file_count);
        if ($urandom_range(0, 99) < 55)
            return FL_NONE;
        return flaw_t'($urandom_range(1, int'(FL_COUNT) - 1));
    endfunction

    task test_zero_track_header();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stim_first = 1'b1;
        put_word(TAG_FILE, 4);
        put_word(HDR_LEN, 4);
        put_word(32'h0000_FFFF, 2);
        put_word(32'h0000_0000, 2);
        put_word(32'h0000_FFFF, 2);
        put(TAG_FILE[31:24]);
        send_stream();
    endtask

    task test_header_errors();
        stim_first = 1'b1;
        put_word(TAG_FILE + 32'd1, 4);
        stim_first = 1'b1;
        put_word(TAG_FILE, 4);
        put_word(HDR_LEN + 32'd1, 4);
        send_stream();
    endtask

    task test_random_files(input int send_pct, input int recv_pct, input int n);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (stim_q.size() < n)
        begin
            gen_file(pick_flaw(), 5);
            file_count++;
        end
        send_stream();
    endtask

    task test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = HOLD_CYCLES;
        hold_starts++;
        gen_file(FL_NONE, 16);
        send_stream();
    endtask

    always @(posedge clk)
    begin
        if (hold_ack != hold_starts)
        begin
            hold_ack = hold_starts;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
                report_mismatch("result with nothing pending, kind", 32'(m_axis_tuser), 0);
            else
            begin
                check_field("kind", 32'(m_axis_tuser), 32'(pending_events[0].kind));
                check_field("delta", 32'(m_axis_tdata[27:0]),
                            32'(pending_events[0].delta));
                check_field("event_type", 32'(m_axis_tdata[35:28]),
                            32'(pending_events[0].event_type));
                check_field("channel", 32'(m_axis_tdata[39:36]),
                            32'(pending_events[0].channel));
                check_field("param_first", 32'(m_axis_tdata[47:40]),
                            32'(pending_events[0].param_first));
                check_field("param_second", 32'(m_axis_tdata[55:48]),
                            32'(pending_events[0].param_second));
                check_field("meta_length", 32'(m_axis_tdata[83:56]),
                            32'(pending_events[0].meta_length));
                check_field("data_byte", 32'(m_axis_tdata[91:84]),
                            32'(pending_events[0].data_byte));
                check_field("file_format", 32'(m_axis_tdata[107:92]),
                            32'(pending_events[0].file_format));
                check_field("track_count", 32'(m_axis_tdata[123:108]),
                            32'(pending_events[0].track_count));
                check_field("division_flag", 32'(m_axis_tdata[124]),
                            32'(pending_events[0].division_flag));
                check_field("time_division", 32'(m_axis_tdata[139:125]),
                            32'(pending_events[0].time_division));
                void'(pending_events.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("midi_file_stream_parser_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int drain_cycles;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_zero_track_header();
        test_header_errors();
        test_random_files(0, 0, 140);
        test_random_files(81, 0, 140);
        test_random_files(0, 81, 140);
        test_random_files(34, 34, 140);
        test_output_backpressure();
        recv_stall_pct = 0;
        drain_cycles = 0;
        while (pending_events.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_events.size() != 0)
            report_mismatch("results never delivered", pending_events.size(), 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("midi_file_stream_parser_unit: match");
        else
            $display("midi_file_stream_parser_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
